>>> rtl/core/arhp_pkg.sv
`timescale 1ns / 1ps
package arhp_pkg;

    // Parser phase codes
    typedef enum logic [2:0] {
        PH_VER    = 3'd0,
        PH_PASS   = 3'd1,
        PH_TYPE   = 3'd2,
        PH_METHOD = 3'd3,
        PH_RESV   = 3'd4,
        PH_VALUE  = 3'd5,
        PH_DONE   = 3'd6,
        PH_ERROR  = 3'd7
    } arhp_phase_t;

    // Reported status codes
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Header constants
    localparam logic [7:0] VERSION_OK   = 8'h01;
    localparam logic [7:0] TYPE_MAX     = 8'h02;
    localparam logic [7:0] METHOD_MAX   = 8'h07;
    localparam logic [7:0] METHOD_BAD   = 8'h02;

    localparam int PASS_W = 48;

    // Complete parser state
    typedef struct packed {
        arhp_phase_t        phase;
        logic [2:0]         byte_count;
        logic [PASS_W-1:0]  pass;
        logic [1:0]         rtype;
        logic [2:0]         method;
        logic [7:0]         resv;
        logic [15:0]        value;
    } arhp_state_t;

    localparam arhp_state_t STATE_CLEAR = '{
        phase:      PH_VER,
        byte_count: 3'd0,
        pass:       '0,
        rtype:      2'd0,
        method:     3'd0,
        resv:       8'd0,
        value:      16'd0
    };

endpackage

>>> rtl/core/admin_request_header_parser.sv
`timescale 1ns / 1ps
// An accepted request byte's result is registered onto m_tdata in the next cycle.
// Throughput: 1 byte per cycle while the output is not stalled; the output register frees when m_tready is high,
// so s_tready = !m_tvalid || m_tready.
// Reset (aresetn low, synchronous): phase back to version byte, all captured
// fields cleared to zero, no result pending.
module admin_request_header_parser #(
    parameter int PASS_BYTES = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] data_byte
    input  logic [7:0]  s_tdata,
    // s_tuser: [0] restart
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [1:0] status, [49:2] passphrase, [51:50] request_type,
    //          [54:52] method, [62:55] reserved_byte, [78:63] value, [79] zero
    output logic [79:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import arhp_pkg::*;

    arhp_state_t state_reg;
    arhp_state_t state_next;
    logic [79:0] m_tdata_reg;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic        s_accept;
    logic [1:0]  status_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Byte decode
    arhp_next #(
        .PASS_BYTES(PASS_BYTES)
    ) u_next (
        .state_cur  (state_reg),
        .data_byte  (s_tdata),
        .restart    (s_tuser[0]),
        .state_next (state_next)
    );

    // Status from the updated phase
    always_comb begin
        unique case (state_next.phase)
            PH_DONE:  status_next = ST_DONE;
            PH_ERROR: status_next = ST_ERROR;
            default:  status_next = ST_BUSY;
        endcase
    end

    // Output valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Parser state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                state_reg <= state_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {1'b0, state_next.value, state_next.resv,
                            state_next.method, state_next.rtype,
                            state_next.pass, status_next};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef ASSERT_OFF
    // Every accepted request yields a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("no result after accepted request");

    // Done and error hold without restart
    a_sticky_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tuser[0] &&
         (state_reg.phase == PH_DONE || state_reg.phase == PH_ERROR))
        |=> $stable(state_reg))
        else $error("terminal phase changed without restart");

    // Passphrase count stays within the passphrase length
    a_pass_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_PASS) |-> (state_reg.byte_count <= 3'(PASS_BYTES - 1)))
        else $error("passphrase count out of range");

    // Reported method is never the forbidden code
    a_method_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[54:52] != METHOD_BAD[2:0]))
        else $error("forbidden method reported");

    // Done status agrees with the stored done phase
    a_status_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> ((m_tdata[1:0] == ST_DONE) == (state_reg.phase == PH_DONE)))
        else $error("status does not match phase");
`endif

endmodule

>>> rtl/core/arhp_next.sv
`timescale 1ns / 1ps
module arhp_next #(
    parameter int PASS_BYTES = 6
) (
    input  arhp_pkg::arhp_state_t state_cur,
    input  logic [7:0]            data_byte,
    input  logic                  restart,
    output arhp_pkg::arhp_state_t state_next
);
    import arhp_pkg::*;

    localparam logic [2:0] PASS_LAST = 3'(PASS_BYTES - 1);

    arhp_state_t base;

    // Restart clears everything, then this byte is the version byte
    assign base = restart ? STATE_CLEAR : state_cur;

    // One header byte per request
    always_comb begin
        state_next = base;
        unique case (base.phase)
            PH_VER: begin
                if (data_byte != VERSION_OK) begin
                    state_next.phase = PH_ERROR;
                end else begin
                    state_next.byte_count = 3'd0;
                    state_next.phase      = PH_PASS;
                end
            end
            PH_PASS: begin
                state_next.pass = {base.pass[PASS_W-9:0], data_byte};
                if (base.byte_count >= PASS_LAST) begin
                    state_next.byte_count = 3'd0;
                    state_next.phase      = PH_TYPE;
                end else begin
                    state_next.byte_count = base.byte_count + 3'd1;
                end
            end
            PH_TYPE: begin
                if (data_byte > TYPE_MAX) begin
                    state_next.phase = PH_ERROR;
                end else begin
                    state_next.rtype = data_byte[1:0];
                    state_next.phase = PH_METHOD;
                end
            end
            PH_METHOD: begin
                if (data_byte > METHOD_MAX || data_byte == METHOD_BAD) begin
                    state_next.phase = PH_ERROR;
                end else begin
                    state_next.method = data_byte[2:0];
                    state_next.phase  = PH_RESV;
                end
            end
            PH_RESV: begin
                state_next.resv       = data_byte;
                state_next.byte_count = 3'd0;
                state_next.phase      = PH_VALUE;
            end
            PH_VALUE: begin
                if (base.byte_count == 3'd0) begin
                    state_next.value      = {data_byte, 8'h00};
                    state_next.byte_count = 3'd1;
                end else begin
                    state_next.value      = {base.value[15:8], data_byte};
                    state_next.byte_count = 3'd0;
                    state_next.phase      = PH_DONE;
                end
            end
            PH_DONE, PH_ERROR: begin
                // sticky: hold until restart
                state_next = base;
            end
        endcase
    end

endmodule
